// ----- hdl/rkc_pkg.sv -----
// Shared types, constants and the saturation helper for the RK4 cubic oscillator step.
// Used by rkc_stage, rkc_finish and rk4_cubic_oscillator_step; depends on nothing.
`default_nettype none

package rkc_pkg;

	localparam int VAL_W  = 32;  // Q8.24 value width
	localparam int STEP_W = 25;  // unsigned time step width
	localparam int SUM_W  = 35;  // exact k1 + 2*(k2 + k3) + k4

	localparam logic [STEP_W-1:0] STEP_RESET = 25'd167772;

	// floor((2^32 - 1) / 3), the reciprocal used for the divide by three
	localparam logic [31:0] RECIP3 = 32'h5555_5555;

	// Role of one evaluation stage in the RK4 chain.
	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_THIRD  = 2'd2;
	localparam logic [1:0] KIND_LAST   = 2'd3;

	localparam logic [1:0] KIND_ORDER [4] = '{KIND_FIRST, KIND_SECOND, KIND_THIRD, KIND_LAST};

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] val;
	} sat_t;

	// Item record that travels between the evaluation stages.
	typedef struct packed {
		logic signed [VAL_W-1:0] pos0;     // position at the start of the step
		logic signed [VAL_W-1:0] mom0;     // momentum at the start of the step
		logic signed [VAL_W-1:0] pos;      // argument of the next evaluation
		logic signed [VAL_W-1:0] mom;
		logic signed [SUM_W-1:0] sum_pos;  // weighted sum of the k values so far
		logic signed [SUM_W-1:0] sum_mom;
		logic                    sat;
	} rec_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] pos;
		logic signed [VAL_W-1:0] mom;
		logic                    sat;
	} res_t;

	// Clip a wide signed value to the 32-bit range and report whether it was clipped.
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		priority if (v > 64'sd2147483647) begin
			r.hit = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r.hit = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.hit = 1'b0;
			r.val = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/rkc_stage.sv -----
// One derivative evaluation of the RK4 step as a six-stage pipeline, plus the stage argument update.
// Depends on rkc_pkg for the item record, the stage role codes and sat32.
`default_nettype none

module rkc_stage #(
	parameter int         FRAC_BITS = 24,
	parameter logic [1:0] KIND      = rkc_pkg::KIND_FIRST
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rkc_pkg::STEP_W-1:0]  dt,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rkc_pkg::rec_t               in_rec,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output rkc_pkg::rec_t                    out_rec
);

	localparam int MUL_W = 58;               // signed dt times a 32-bit value
	localparam int SQ_W  = 64 - FRAC_BITS;   // rounded square, never negative
	localparam logic signed [MUL_W-1:0] RND_M = {{(MUL_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
	localparam logic signed [63:0]      RND_Q = {{63{1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	rkc_pkg::rec_t rec_s1, rec_s2, rec_s3, rec_s4, rec_s5, rec_s6;

	logic signed [63:0]               prod_qq_s1;
	logic signed [MUL_W-1:0]          prod_dq_s1;
	logic signed [SQ_W-1:0]           sq_s2;
	logic signed [rkc_pkg::VAL_W-1:0] kq_s2, kq_s3, kq_s4, kq_s5;
	logic signed [rkc_pkg::VAL_W-1:0] dp_s3;
	logic signed [MUL_W-1:0]          prod_dp_s4;
	logic signed [rkc_pkg::VAL_W-1:0] kp_s5;

	// A stage moves on when it is empty or when the next one moves on.
	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	logic signed [MUL_W-1:0] dt_ext;
	logic signed [MUL_W-1:0] p_ext;
	logic signed [63:0]      q_ext;
	logic signed [MUL_W-1:0] dp_ext;

	assign dt_ext = {{(MUL_W-rkc_pkg::STEP_W){1'b0}}, dt};
	assign p_ext  = {{(MUL_W-rkc_pkg::VAL_W){in_rec.mom[rkc_pkg::VAL_W-1]}}, in_rec.mom};
	assign q_ext  = {{(64-rkc_pkg::VAL_W){in_rec.pos[rkc_pkg::VAL_W-1]}}, in_rec.pos};
	assign dp_ext = {{(MUL_W-rkc_pkg::VAL_W){dp_s3[rkc_pkg::VAL_W-1]}}, dp_s3};

	// Stage 2: rounding of both products
	logic signed [63:0]      sq_full;
	logic signed [MUL_W-1:0] kq_full;
	rkc_pkg::sat_t           kq_sat;

	always_comb begin
		sq_full = (prod_qq_s1 + RND_Q) >>> FRAC_BITS;
		kq_full = (prod_dq_s1 + RND_M) >>> FRAC_BITS;
		kq_sat  = rkc_pkg::sat32(64'(kq_full));
	end

	// Stage 3: dp = -(3*q^2 + q)
	rkc_pkg::sat_t dp_sat;

	always_comb begin
		dp_sat = rkc_pkg::sat32(-((64'(sq_s2) * 64'sd3) + 64'(rec_s2.pos)));
	end

	// Stage 5: rounding of dt*dp
	logic signed [MUL_W-1:0] kp_full;
	rkc_pkg::sat_t           kp_sat;

	always_comb begin
		kp_full = (prod_dp_s4 + RND_M) >>> FRAC_BITS;
		kp_sat  = rkc_pkg::sat32(64'(kp_full));
	end

	// Records with the clip flag of the stage that can clip folded in.
	rkc_pkg::rec_t rec_nx2, rec_nx3, rec_nx5;

	always_comb begin
		rec_nx2     = rec_s1;
		rec_nx2.sat = rec_s1.sat | kq_sat.hit;
		rec_nx3     = rec_s2;
		rec_nx3.sat = rec_s2.sat | dp_sat.hit;
		rec_nx5     = rec_s4;
		rec_nx5.sat = rec_s4.sat | kp_sat.hit;
	end

	// Stage 6: weighted sum and the argument of the next evaluation
	logic signed [rkc_pkg::VAL_W:0]   hq_tmp, hp_tmp;
	logic signed [rkc_pkg::VAL_W-1:0] hq, hp;
	rkc_pkg::sat_t                    nq, np;
	rkc_pkg::rec_t                    nxt;

	always_comb begin
		hq_tmp = ({kq_s5[rkc_pkg::VAL_W-1], kq_s5} + 33'sd1) >>> 1;
		hp_tmp = ({kp_s5[rkc_pkg::VAL_W-1], kp_s5} + 33'sd1) >>> 1;
		hq     = hq_tmp[rkc_pkg::VAL_W-1:0];
		hp     = hp_tmp[rkc_pkg::VAL_W-1:0];
		nxt    = rec_s5;
		nq     = '{hit: 1'b0, val: rec_s5.pos};
		np     = '{hit: 1'b0, val: rec_s5.mom};
		unique case (KIND)
			rkc_pkg::KIND_FIRST: begin
				nxt.sum_pos = rkc_pkg::SUM_W'(kq_s5);
				nxt.sum_mom = rkc_pkg::SUM_W'(kp_s5);
				nq = rkc_pkg::sat32(64'(rec_s5.pos0) + 64'(hq));
				np = rkc_pkg::sat32(64'(rec_s5.mom0) + 64'(hp));
			end
			rkc_pkg::KIND_SECOND: begin
				nxt.sum_pos = rec_s5.sum_pos + (rkc_pkg::SUM_W'(kq_s5) <<< 1);
				nxt.sum_mom = rec_s5.sum_mom + (rkc_pkg::SUM_W'(kp_s5) <<< 1);
				nq = rkc_pkg::sat32(64'(rec_s5.pos0) + 64'(hq));
				np = rkc_pkg::sat32(64'(rec_s5.mom0) + 64'(hp));
			end
			rkc_pkg::KIND_THIRD: begin
				nxt.sum_pos = rec_s5.sum_pos + (rkc_pkg::SUM_W'(kq_s5) <<< 1);
				nxt.sum_mom = rec_s5.sum_mom + (rkc_pkg::SUM_W'(kp_s5) <<< 1);
				nq = rkc_pkg::sat32(64'(rec_s5.pos0) + 64'(kq_s5));
				np = rkc_pkg::sat32(64'(rec_s5.mom0) + 64'(kp_s5));
			end
			rkc_pkg::KIND_LAST: begin
				// The last evaluation feeds no further argument.
				nxt.sum_pos = rec_s5.sum_pos + rkc_pkg::SUM_W'(kq_s5);
				nxt.sum_mom = rec_s5.sum_mom + rkc_pkg::SUM_W'(kp_s5);
			end
			default: begin
				nxt = rec_s5;
			end
		endcase
		nxt.pos = nq.val;
		nxt.mom = np.val;
		nxt.sat = rec_s5.sat | nq.hit | np.hit;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rec_s1     <= in_rec;
			prod_qq_s1 <= q_ext * q_ext;
			prod_dq_s1 <= dt_ext * p_ext;
		end
		if (en2) begin
			rec_s2     <= rec_nx2;
			sq_s2      <= sq_full[SQ_W-1:0];
			kq_s2      <= kq_sat.val;
		end
		if (en3) begin
			rec_s3     <= rec_nx3;
			dp_s3      <= dp_sat.val;
			kq_s3      <= kq_s2;
		end
		if (en4) begin
			rec_s4     <= rec_s3;
			prod_dp_s4 <= dt_ext * dp_ext;
			kq_s4      <= kq_s3;
		end
		if (en5) begin
			rec_s5     <= rec_nx5;
			kp_s5      <= kp_sat.val;
			kq_s5      <= kq_s4;
		end
		if (en6) begin
			rec_s6 <= nxt;
		end
	end

	assign out_valid = v_s6;
	assign out_rec   = rec_s6;

endmodule

`default_nettype wire

// ----- hdl/rkc_finish.sv -----
// Final RK4 combination: weighted sum over six, rounded half away from zero, added and clipped.
// Four-stage pipeline; depends on rkc_pkg for the record types, RECIP3 and sat32.
`default_nettype none

module rkc_finish (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rkc_pkg::rec_t in_rec,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rkc_pkg::res_t      out_res
);

	localparam int X_W = 33;   // (|sum| + 3) / 2 stays below 2^33

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [rkc_pkg::VAL_W-1:0] u_s1 [2];
	logic signed [rkc_pkg::VAL_W-1:0] u_s2 [2];
	logic signed [rkc_pkg::VAL_W-1:0] u_s3 [2];
	logic        [X_W-1:0]            x_s1 [2];
	logic        [X_W-1:0]            x_s2 [2];
	logic        [X_W+31:0]           prod_s2 [2];
	logic signed [X_W:0]              inc_s3 [2];
	logic                             neg_s1 [2];
	logic                             neg_s2 [2];
	logic                             sat_s1, sat_s2, sat_s3;
	rkc_pkg::res_t                    res_s4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	logic signed [rkc_pkg::SUM_W-1:0] sum_in [2];
	logic signed [rkc_pkg::VAL_W-1:0] u_in   [2];
	logic        [rkc_pkg::SUM_W-1:0] mag    [2];
	logic        [rkc_pkg::SUM_W-1:0] mag3   [2];
	logic        [X_W-1:0]            q0     [2];
	logic        [X_W-1:0]            rem    [2];
	logic        [X_W-1:0]            quot   [2];
	rkc_pkg::sat_t                    fin    [2];

	assign sum_in[0] = in_rec.sum_pos;
	assign sum_in[1] = in_rec.sum_mom;
	assign u_in[0]   = in_rec.pos0;
	assign u_in[1]   = in_rec.mom0;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag[i]  = sum_in[i][rkc_pkg::SUM_W-1] ? -sum_in[i] : sum_in[i];
			mag3[i] = mag[i] + rkc_pkg::SUM_W'(3);
			// Reciprocal estimate is at most one short; the remainder fixes it.
			q0[i]   = prod_s2[i][X_W+31:32];
			rem[i]  = x_s2[i] - X_W'(q0[i] * X_W'(3));
			priority if (rem[i] >= X_W'(6)) quot[i] = q0[i] + X_W'(2);
			else if (rem[i] >= X_W'(3))     quot[i] = q0[i] + X_W'(1);
			else                            quot[i] = q0[i];
			fin[i]  = rkc_pkg::sat32(64'(u_s3[i]) + 64'(inc_s3[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (en1) begin
				x_s1[i]   <= mag3[i][X_W:1];
				neg_s1[i] <= sum_in[i][rkc_pkg::SUM_W-1];
				u_s1[i]   <= u_in[i];
			end
			if (en2) begin
				prod_s2[i] <= (X_W+32)'(x_s1[i]) * (X_W+32)'(rkc_pkg::RECIP3);
				x_s2[i]    <= x_s1[i];
				neg_s2[i]  <= neg_s1[i];
				u_s2[i]    <= u_s1[i];
			end
			if (en3) begin
				inc_s3[i] <= neg_s2[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
				u_s3[i]   <= u_s2[i];
			end
		end
		if (en1) sat_s1 <= in_rec.sat;
		if (en2) sat_s2 <= sat_s1;
		if (en3) sat_s3 <= sat_s2;
		if (en4) begin
			res_s4.pos <= fin[0].val;
			res_s4.mom <= fin[1].val;
			res_s4.sat <= sat_s3 | fin[0].hit | fin[1].hit;
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

`default_nettype wire

// ----- hdl/rk4_cubic_oscillator_step.sv -----
// Top level of the RK4 step for the cubic oscillator dq/dt = p, dp/dt = -(3q^2 + q).
// Chains four rkc_stage evaluations and rkc_finish; depends on rkc_pkg.
//
// Use: each beat on the slave stream carries a state pair (position, momentum) in signed
// Q8.24; each beat on the master stream carries the pair one time step later and a flag
// that is set when any intermediate or final value was clipped to the 32-bit range.
// Pairs are independent, so many trajectories can be interleaved freely.
// The time step dt is written through the configuration channel, which is always ready;
// write it only while no beat is in flight.
// Throughput: one beat per clock while the master side accepts results. Each input beat
// passes the four derivative evaluations (square, round, scale by dt twice, argument
// update) and then the final divide by six and add.
// Every pipeline stage moves on when it is empty or its successor moves on, so a stall
// at the master side only fills the bubbles ahead of it; input is refused once every
// stage holds a beat. Nothing is lost or repeated while stalled.
// Reset empties the pipeline and sets dt to 0.01.
`default_nettype none

module rk4_cubic_oscillator_step #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,    // position [31:0], momentum [63:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,    // next_position [31:0], next_momentum [63:32]
	output logic [0:0]       m_tuser,    // saturated [0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [24:0] cfg_data    // step_size, unsigned Q1.24
);

	logic [rkc_pkg::STEP_W-1:0] step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rkc_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	// Link 0 is the input; link 4 feeds the final combination.
	logic          link_valid [5];
	logic          link_ready [5];
	rkc_pkg::rec_t link_rec   [5];

	always_comb begin
		link_rec[0].pos0    = s_tdata[31:0];
		link_rec[0].mom0    = s_tdata[63:32];
		link_rec[0].pos     = s_tdata[31:0];
		link_rec[0].mom     = s_tdata[63:32];
		link_rec[0].sum_pos = '0;
		link_rec[0].sum_mom = '0;
		link_rec[0].sat     = 1'b0;
	end

	assign link_valid[0] = s_tvalid;
	assign s_tready      = link_ready[0];

	for (genvar g = 0; g < 4; g++) begin : g_eval
		rkc_stage #(
			.FRAC_BITS (FRAC_BITS),
			.KIND      (rkc_pkg::KIND_ORDER[g])
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.dt        (step_q),
			.in_valid  (link_valid[g]),
			.in_ready  (link_ready[g]),
			.in_rec    (link_rec[g]),
			.out_valid (link_valid[g+1]),
			.out_ready (link_ready[g+1]),
			.out_rec   (link_rec[g+1])
		);
	end

	rkc_pkg::res_t res;

	rkc_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[4]),
		.in_ready  (link_ready[4]),
		.in_rec    (link_rec[4]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.mom, res.pos};
	assign m_tuser = res.sat;

`ifndef SYNTHESIS
	// Input is only ever refused because the result side holds the pipeline back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input refused without output back-pressure");

	// An idle output means every stage can take a beat.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused while output is empty");

	// A configuration beat lands in the step register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (step_q == $past(cfg_data)))
		else $error("step size write lost");

	// A beat held between the last evaluation and the final combination keeps its data.
	a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(link_valid[4] && !link_ready[4]) |=> (link_valid[4] && $stable(link_rec[4])))
		else $error("stalled beat changed inside the pipeline");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for rk4_cubic_oscillator_step: random and corner state pairs under
// several step sizes, checked against a bit-exact RK4 predictor held in this file.
// Depends on rkc_pkg and the RTL top level only.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 24;           // fraction bits of the Q8.24 format
	localparam int PHASE_BEATS = 265;   // random state pairs per step-size phase
	localparam int STALL_LEN = 150;     // long receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 40;   // wait after the last check, with margin over the pipeline depth

	// One RK4 result as it appears on the master stream.
	typedef struct {
		logic signed [rkc_pkg::VAL_W-1:0] pos;
		logic signed [rkc_pkg::VAL_W-1:0] mom;
		logic                             sat;
	} step_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [63:0]                s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [63:0]                m_tdata;
	logic [0:0]                 m_tuser;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [rkc_pkg::STEP_W-1:0] cfg_data = '0;

	// State pairs waiting to be sent; the head stays here until its beat is accepted,
	// so an empty queue really means the sender has nothing left on the bus.
	logic [63:0]  pairs_to_send[$];
	step_result_t expected_steps[$];

	// Step size the block currently holds; only changed while nothing is in flight.
	logic [rkc_pkg::STEP_W-1:0] dt_now = rkc_pkg::STEP_RESET;

	int unsigned tx_idle_pct = 28;
	int unsigned rx_idle_pct = 28;
	bit          stall_kick = 1'b0;
	bit          stall_kick_seen;
	int unsigned hold_left;

	int unsigned err_count = 0;
	int unsigned steps_checked = 0;
	int unsigned clipped_seen = 0;

	rk4_cubic_oscillator_step #(.FRAC_BITS(FRAC)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Predictor. All arithmetic is carried out in 64-bit signed integers, which is wide
	// enough for every product and sum in one step; each stage value and the results
	// are clipped to the 32-bit range, and any clipping sets the flag.
	// ---------------------------------------------------------------------------------
	function automatic longint clip_s32(input longint v, inout bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Fixed-point product, rounded to nearest with ties towards plus infinity.
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// One derivative evaluation scaled by dt: k = dt * (p, -(3q^2 + q)).
	function automatic void slope_times_dt(input longint dt, input longint q, input longint p,
			output longint kq, output longint kp, inout bit hit);
		longint dp;
		dp = clip_s32(-(3 * fx_mul(q, q) + q), hit);
		kq = clip_s32(fx_mul(dt, p), hit);
		kp = clip_s32(fx_mul(dt, dp), hit);
	endfunction

	// Weighted RK4 increment divided by six, rounded half away from zero, added to u.
	function automatic longint rk4_combine(input longint u, input longint k1, input longint k2,
			input longint k3, input longint k4, inout bit hit);
		longint s;
		longint inc;
		s = k1 + 2 * (k2 + k3) + k4;
		inc = (s >= 0) ? (s + 3) / 6 : (s - 3) / 6;
		return clip_s32(u + inc, hit);
	endfunction

	function automatic step_result_t rk4_advance(input logic [63:0] pair,
			input logic [rkc_pkg::STEP_W-1:0] step);
		step_result_t r;
		bit     hit;
		longint dt, q, p;
		longint k1q, k1p, k2q, k2p, k3q, k3p, k4q, k4p;
		hit = 1'b0;
		dt = longint'(step);
		q = longint'($signed(pair[31:0]));
		p = longint'($signed(pair[63:32]));
		slope_times_dt(dt, q, p, k1q, k1p, hit);
		slope_times_dt(dt, clip_s32(q + ((k1q + 1) >>> 1), hit),
			clip_s32(p + ((k1p + 1) >>> 1), hit), k2q, k2p, hit);
		slope_times_dt(dt, clip_s32(q + ((k2q + 1) >>> 1), hit),
			clip_s32(p + ((k2p + 1) >>> 1), hit), k3q, k3p, hit);
		slope_times_dt(dt, clip_s32(q + k3q, hit), clip_s32(p + k3p, hit), k4q, k4p, hit);
		r.pos = 32'(rk4_combine(q, k1q, k2q, k3q, k4q, hit));
		r.mom = 32'(rk4_combine(p, k1p, k2p, k3p, k4p, hit));
		r.sat = hit;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Sender. A beat is held until it is taken; between beats the sender may idle at
	// random. The prediction is made at the very edge on which the beat is accepted,
	// using the step size in force at that moment.
	// ---------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_steps.push_back(rk4_advance(pairs_to_send.pop_front(), dt_now));
			end
			if (!s_tvalid || s_tready) begin
				if (pairs_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tdata  <= pairs_to_send[0];
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Receiver. Each accepted beat is compared with the oldest expectation, field by
	// field. A change of stall_kick starts a long hold-off that this process counts out
	// itself, so the pipeline fills and the block has to refuse input.
	// ---------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready        <= 1'b0;
			hold_left       <= 0;
			stall_kick_seen <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_steps.size() == 0) begin
					$error("result beat with no state pair outstanding: data %h, flag %b",
						m_tdata, m_tuser[0]);
					err_count = err_count + 1;
				end else begin
					step_result_t want;
					want = expected_steps.pop_front();
					if (m_tdata[31:0] !== want.pos) begin
						$error("next_position: expected %0d, got %0d", want.pos,
							$signed(m_tdata[31:0]));
						err_count = err_count + 1;
					end
					if (m_tdata[63:32] !== want.mom) begin
						$error("next_momentum: expected %0d, got %0d", want.mom,
							$signed(m_tdata[63:32]));
						err_count = err_count + 1;
					end
					if (m_tuser[0] !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, m_tuser[0]);
						err_count = err_count + 1;
					end
					steps_checked <= steps_checked + 1;
					if (want.sat)
						clipped_seen <= clipped_seen + 1;
				end
			end
			if (stall_kick != stall_kick_seen) begin
				stall_kick_seen <= stall_kick;
				hold_left       <= STALL_LEN;
				m_tready        <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus and sequencing.
	// ---------------------------------------------------------------------------------
	task automatic queue_pair(input logic [31:0] q, input logic [31:0] p);
		pairs_to_send.push_back({p, q});
	endtask

	// Mostly physically sensible coordinates, with moderate, extreme and fully random
	// values mixed in so that every bit of both fields toggles.
	function automatic logic [31:0] random_coord();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return 32'($urandom_range(32'h07FF_FFFF)) - 32'h0400_0000;
		else if (pick < 72)
			return 32'($urandom_range(32'h3FFF_FFFF)) - 32'h2000_0000;
		else if (pick < 78)
			case ($urandom_range(4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		else
			return $urandom;
	endfunction

	// Sender pause: nothing more is queued until every expectation has been met.
	task automatic wait_until_drained();
		while (pairs_to_send.size() != 0 || expected_steps.size() != 0)
			@(posedge clk);
	endtask

	// Only called once the pipeline is empty, so no beat sees the change half way.
	task automatic write_step_size(input logic [rkc_pkg::STEP_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dt_now = value;
	endtask

	initial begin
		logic [rkc_pkg::STEP_W-1:0] step_plan[6];
		step_plan = '{rkc_pkg::STEP_RESET, 25'd0, 25'd1, 25'h100_0000, 25'h1FF_FFFF, 25'd0};
		step_plan[5] = rkc_pkg::STEP_W'($urandom_range(25'h1FF_FFFF));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset step size: range extremes, unit values, values whose
		// square overflows the Q8.24 range, and a few small or odd patterns.
		queue_pair(32'h0000_0000, 32'h0000_0000);
		queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_pair(32'h8000_0000, 32'h8000_0000);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000);
		queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
		queue_pair(32'h0100_0000, 32'h0000_0000);
		queue_pair(32'hFF00_0000, 32'h0000_0000);
		queue_pair(32'h0000_0000, 32'h0100_0000);
		queue_pair(32'h0000_0000, 32'hFF00_0000);
		queue_pair(32'h0000_0001, 32'hFFFF_FFFF);
		queue_pair(32'hFFFF_FFFF, 32'h0000_0001);
		queue_pair(32'h1000_0000, 32'h0000_0000);
		queue_pair(32'hF000_0000, 32'h0000_0000);
		queue_pair(32'h0000_0000, 32'h4000_0000);
		queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
		queue_pair(32'h0080_0000, 32'h0080_0000);
		queue_pair(32'h06A0_9E66, 32'hF95F_619A);
		wait_until_drained();

		// With dt of one LSB, dt * p lands exactly half way for p = +/-0.5; ties go up.
		write_step_size(25'd1);
		queue_pair(32'h0000_0000, 32'h0080_0000);
		queue_pair(32'h0000_0000, 32'hFF80_0000);
		queue_pair(32'h0000_0000, 32'h0180_0000);
		queue_pair(32'h0000_0000, 32'hFE80_0000);
		wait_until_drained();

		foreach (step_plan[i]) begin
			write_step_size(step_plan[i]);
			// Second phase runs flat out on both sides; the rest idle at random.
			tx_idle_pct = (i == 1) ? 0 : 28;
			rx_idle_pct = (i == 1) ? 0 : 28;
			repeat (PHASE_BEATS)
				queue_pair(random_coord(), random_coord());
			// Third phase starts with the receiver blocked while the sender keeps offering.
			if (i == 2)
				stall_kick = ~stall_kick;
			wait_until_drained();
		end

		// Give any stray beat time to come out and be flagged.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d RK4 steps over %0d step sizes from zero to the 25-bit maximum,",
			steps_checked, 6);
		$display("%0d of them clipped; a long output stall back-pressured the input.",
			clipped_seen);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: set far beyond the run time that a correct run needs.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
